FILE: hdl/kbre_pkg.sv
// ----------------------------------------------------------------------------
// kbre_pkg: shared constants for the keyboard report event core
// Report layout limits, event coding and queue sizing.
// ----------------------------------------------------------------------------
package kbre_pkg;

  localparam int MOD_BITS    = 8;
  localparam int CODE_W      = 8;
  localparam int LEN_W       = 7;
  localparam int MAX_SLOTS   = 6;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 8;

  localparam logic [LEN_W-1:0]  MIN_REPORT_BYTES = 7'd8;
  localparam logic [CODE_W-1:0] MODIFIER_BASE    = 8'hE0;
  localparam logic [CODE_W-1:0] LIMIT_RESET      = 8'd3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic push;
  } queue_ctl_t;

endpackage

FILE: hdl/kbre_front.sv
// ----------------------------------------------------------------------------
// kbre_front: report intake and difference classification
// Compares each report with the stored one and builds the event mask.
// ----------------------------------------------------------------------------
module kbre_front #(
  parameter int KEY_SLOTS = 6,
  localparam int EVENTS  = kbre_pkg::MOD_BITS + 2 * KEY_SLOTS,
  localparam int ENTRY_W = EVENTS + kbre_pkg::MOD_BITS + 2 * kbre_pkg::CODE_W * KEY_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [kbre_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kbre_pkg::CODE_W-1:0]     cfg_data,
  output kbre_pkg::queue_ctl_t            qctl,
  input  logic                            q_ready,
  output logic [ENTRY_W-1:0]              entry
);

  localparam int CW = kbre_pkg::CODE_W;
  localparam int MB = kbre_pkg::MOD_BITS;
  localparam int LW = kbre_pkg::LEN_W;

  logic [CW-1:0] limit;
  logic [MB-1:0] prev_mods;
  logic [CW-1:0] stored_keys [KEY_SLOTS];

  logic [LW-1:0]     len;
  logic [MB-1:0]     mods;
  logic [CW-1:0]     cur [KEY_SLOTS];
  logic [EVENTS-1:0] mask;
  logic              long_enough;
  logic              accept;
  logic [CW*KEY_SLOTS-1:0] prev_flat;
  logic [CW*KEY_SLOTS-1:0] cur_flat;

  always_comb begin
    logic in_cur;
    logic in_prev;
    len  = s_tdata[LW-1:0];
    mods = s_tdata[LW +: MB];
    for (int i = 0; i < KEY_SLOTS; i++) begin
      cur[i] = s_tdata[LW + MB + CW * i +: CW];
      prev_flat[CW * i +: CW] = stored_keys[i];
      cur_flat[CW * i +: CW]  = cur[i];
    end
    mask[MB-1:0] = prev_mods ^ mods;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      in_cur  = 1'b0;
      in_prev = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        in_cur  = in_cur  | (cur[j] == stored_keys[i]);
        in_prev = in_prev | (stored_keys[j] == cur[i]);
      end
      mask[MB + 2 * i]     = (stored_keys[i] > limit) && !in_cur;
      mask[MB + 2 * i + 1] = (cur[i] > limit) && !in_prev;
    end
  end

  assign long_enough = (len >= kbre_pkg::MIN_REPORT_BYTES);
  assign s_tready    = q_ready;
  assign accept      = s_tvalid && s_tready;
  assign cfg_ready   = 1'b1;
  assign qctl.push   = accept && long_enough && (|mask);
  assign entry       = {cur_flat, prev_flat, mods, mask};

  always_ff @(posedge clk) begin
    if (rst) begin
      limit     <= kbre_pkg::LIMIT_RESET;
      prev_mods <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) stored_keys[i] <= '0;
    end else begin
      if (cfg_valid) begin
        limit <= cfg_data;
      end
      if (accept && long_enough) begin
        prev_mods <= mods;
        for (int i = 0; i < KEY_SLOTS; i++) stored_keys[i] <= cur[i];
      end
    end
  end

endmodule

FILE: hdl/kbre_queue.sv
// ----------------------------------------------------------------------------
// kbre_queue: short report queue
// Holds classified reports between intake and event output.
// ----------------------------------------------------------------------------
module kbre_queue #(
  parameter int WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  kbre_pkg::queue_ctl_t qctl,
  output logic                 q_ready,
  input  logic [WIDTH-1:0]     wr_data,
  output logic                 q_valid,
  input  logic                 pop,
  output logic [WIDTH-1:0]     rd_data
);

  localparam int D  = kbre_pkg::QUEUE_DEPTH;
  localparam int PW = kbre_pkg::QPTR_W;
  localparam int CW = kbre_pkg::QCNT_W;

  logic [WIDTH-1:0] mem [D];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign q_ready = (count != CW'(D));
  assign q_valid = (count != '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (qctl.push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (qctl.push) begin
        wr_ptr <= (wr_ptr == PW'(D - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(D - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (qctl.push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !qctl.push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    qctl.push |-> (count != CW'(D)))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(D))
    else $error("queue count out of range");
`endif

endmodule

FILE: hdl/kbre_back.sv
// ----------------------------------------------------------------------------
// kbre_back: event serializer
// Emits the events of the queued report one word per cycle while m_tready allows, lowest first.
// ----------------------------------------------------------------------------
module kbre_back #(
  parameter int KEY_SLOTS = 6,
  localparam int EVENTS  = kbre_pkg::MOD_BITS + 2 * KEY_SLOTS,
  localparam int ENTRY_W = EVENTS + kbre_pkg::MOD_BITS + 2 * kbre_pkg::CODE_W * KEY_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  logic [ENTRY_W-1:0]              entry,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [kbre_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tuser,
  output logic                            m_tlast
);

  localparam int CW    = kbre_pkg::CODE_W;
  localparam int MB    = kbre_pkg::MOD_BITS;
  localparam int IDX_W = $clog2(EVENTS);

  logic [EVENTS-1:0] done;
  logic [EVENTS-1:0] mask;
  logic [EVENTS-1:0] remaining;
  logic [EVENTS-1:0] sel;
  logic [MB-1:0]     mods;
  logic [IDX_W-1:0]  idx;
  logic [CW-1:0]     code;
  logic              rel;
  logic              last;
  logic              load;

  assign mask      = entry[EVENTS-1:0];
  assign mods      = entry[EVENTS +: MB];
  assign remaining = mask & ~done;

  always_comb begin
    idx = '0;
    for (int k = EVENTS - 1; k >= 0; k--) begin
      if (remaining[k]) idx = IDX_W'(k);
    end
    sel  = remaining & ~(remaining - 1'b1);
    last = ((remaining & ~sel) == '0);
    code = '0;
    rel  = 1'b0;
    for (int k = 0; k < MB; k++) begin
      if (idx == IDX_W'(k)) begin
        code = kbre_pkg::MODIFIER_BASE + CW'(k);
        rel  = ~mods[k];
      end
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (idx == IDX_W'(MB + 2 * i)) begin
        code = entry[EVENTS + MB + CW * i +: CW];
        rel  = 1'b1;
      end
      if (idx == IDX_W'(MB + 2 * i + 1)) begin
        code = entry[EVENTS + MB + CW * KEY_SLOTS + CW * i +: CW];
        rel  = 1'b0;
      end
    end
  end

  assign load = q_valid && (!m_tvalid || m_tready);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      done     <= '0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        done     <= last ? '0 : (done | sel);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= code;
      m_tuser <= rel;
      m_tlast <= last;
    end
  end

endmodule

FILE: hdl/keyboard_report_key_events_core.sv
// ----------------------------------------------------------------------------
// keyboard_report_key_events_core: keyboard report to key event converter
// Turns boot keyboard reports into a stream of press and release events.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Payload
// s_       in   s_tvalid/s_tready    s_tdata: report_length, modifier_bits,
//                                    key_slot_0 .. key_slot_5
// m_       out  m_tvalid/m_tready    m_tdata: usage_code; m_tuser: released;
//                                    m_tlast: last_event
// cfg_     in   cfg_valid/cfg_ready  cfg_data: error_code_limit
//
// A report is taken whenever the two-entry queue has room.
// Its events leave the serializer one word per cycle while m_tready allows;
// a report has up to 8 + 2 * KEY_SLOTS events.
// A report with no events, or shorter than eight bytes, queues nothing.
// Reset clears the stored report and sets the limit to three.
// Output stalls fill the queue and then hold s_tready low.
// ----------------------------------------------------------------------------
module keyboard_report_key_events_core #(
  parameter int KEY_SLOTS = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // report_length[6:0], modifier_bits[14:7], key_slot_0..5 from bit 15, pad
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // usage_code[7:0]
  output logic [7:0]  m_tdata,
  // released[0]
  output logic        m_tuser,
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int EVENTS  = kbre_pkg::MOD_BITS + 2 * KEY_SLOTS;
  localparam int ENTRY_W = EVENTS + kbre_pkg::MOD_BITS + 2 * kbre_pkg::CODE_W * KEY_SLOTS;

  kbre_pkg::queue_ctl_t qctl;
  logic                 q_ready;
  logic                 q_valid;
  logic                 pop;
  logic [ENTRY_W-1:0]   wr_entry;
  logic [ENTRY_W-1:0]   rd_entry;

  kbre_front #(.KEY_SLOTS(KEY_SLOTS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .qctl      (qctl),
    .q_ready   (q_ready),
    .entry     (wr_entry)
  );

  kbre_queue #(.WIDTH(ENTRY_W)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .qctl    (qctl),
    .q_ready (q_ready),
    .wr_data (wr_entry),
    .q_valid (q_valid),
    .pop     (pop),
    .rd_data (rd_entry)
  );

  kbre_back #(.KEY_SLOTS(KEY_SLOTS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .entry    (rd_entry),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
